@@ rtl/core/lavm_pkg.sv @@
`default_nettype none
package lavm_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int NORM_TOP       = 30;
	localparam int QUEUE_DEPTH    = 2;
	localparam int CNT_W          = 6;
	localparam int NUM_FIELDS     = 9;

	// handshake back from the normalize unit
	typedef struct packed {
		logic done;
		logic zero;
	} norm_sts_t;

	typedef enum logic [5:0] {
		N_IDLE  = 6'b000001,
		N_SHIFT = 6'b000010,
		N_SQ    = 6'b000100,
		N_SQRT  = 6'b001000,
		N_DIVI  = 6'b010000,
		N_DIV   = 6'b100000
	} norm_state_t;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b00000001,
		ST_NDIR   = 8'b00000010,
		ST_NUP    = 8'b00000100,
		ST_CROSS1 = 8'b00001000,
		ST_NX     = 8'b00010000,
		ST_CROSS2 = 8'b00100000,
		ST_DOT    = 8'b01000000,
		ST_EMIT   = 8'b10000000
	} back_state_t;

endpackage
`default_nettype wire

@@ rtl/core/lavm_norm.sv @@
`default_nettype none
module lavm_norm import lavm_pkg::*; #(
	parameter int FW = FRAC_BITS_DEF,
	parameter int IW = 2 * FRAC_BITS_DEF + 3
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic signed [IW-1:0] vx,
	input  wire logic signed [IW-1:0] vy,
	input  wire logic signed [IW-1:0] vz,
	output norm_sts_t                 sts,
	output logic signed [FW+1:0]      ux,
	output logic signed [FW+1:0]      uy,
	output logic signed [FW+1:0]      uz
);

	localparam int MW   = (IW > NORM_TOP + 1) ? IW : NORM_TOP + 1;
	localparam int QW   = FW + 1;
	localparam int NUMW = NORM_TOP + 2 + FW;
	localparam int RW   = 33;

	norm_state_t             st_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [MW-1:0]           m_q [3];
	logic                    neg_q [3];
	logic [63:0]             s_q, r_q, bit_q;
	logic [RW-1:0]           rem_q [3];
	logic [FW:0]             lo_q [3];
	logic [QW-1:0]           q_q [3];
	logic signed [FW+1:0]    u_q [3];
	logic                    done_q, zero_q;

	logic signed [IW-1:0]    vin [3];
	logic [MW-1:0]           orv;
	logic [61:0]             sq;
	logic [63:0]             trial_sq;
	logic [31:0]             len;
	logic [RW-1:0]           trial [3];
	logic                    ge [3];
	logic [QW-1:0]           qn [3];
	logic [NUMW-1:0]         num [3];

	assign vin[0] = vx;
	assign vin[1] = vy;
	assign vin[2] = vz;
	assign orv = m_q[0] | m_q[1] | m_q[2];
	assign sq = m_q[cnt_q[1:0]][NORM_TOP:0] * m_q[cnt_q[1:0]][NORM_TOP:0];
	assign trial_sq = r_q + bit_q;
	assign len = r_q[31:0];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			num[i] = {m_q[i][NORM_TOP:0], {FW{1'b0}}} + NUMW'(len[31:1]);
			trial[i] = {rem_q[i][RW-2:0], lo_q[i][FW]};
			ge[i] = trial[i] >= RW'(len);
			qn[i] = {q_q[i][QW-2:0], ge[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= N_IDLE;
			done_q <= 1'b0;
			zero_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				N_IDLE: begin
					if (start) begin
						st_q <= N_SHIFT;
					end
				end
				N_SHIFT: begin
					if (orv == '0) begin
						zero_q <= 1'b1;
						done_q <= 1'b1;
						st_q <= N_IDLE;
					end else if ((orv >> (NORM_TOP + 1)) == '0 && orv[NORM_TOP]) begin
						cnt_q <= '0;
						st_q <= N_SQ;
					end
				end
				N_SQ: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(2)) begin
						cnt_q <= '0;
						st_q <= N_SQRT;
					end
				end
				N_SQRT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(31)) begin
						st_q <= N_DIVI;
					end
				end
				N_DIVI: begin
					cnt_q <= '0;
					st_q <= N_DIV;
				end
				N_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(FW)) begin
						zero_q <= 1'b0;
						done_q <= 1'b1;
						st_q <= N_IDLE;
					end
				end
				default: st_q <= N_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			N_IDLE: begin
				for (int i = 0; i < 3; i++) begin
					neg_q[i] <= vin[i][IW-1];
					m_q[i] <= MW'(vin[i][IW-1] ? IW'(-vin[i]) : IW'(vin[i]));
				end
			end
			N_SHIFT: begin
				// truncating right shift or left shift, one bit a cycle, until the top bit sits at bit 30
				for (int i = 0; i < 3; i++) begin
					if ((orv >> (NORM_TOP + 1)) != '0) begin
						m_q[i] <= m_q[i] >> 1;
					end else if (!orv[NORM_TOP]) begin
						m_q[i] <= m_q[i] << 1;
					end
				end
				if (orv == '0) begin
					for (int i = 0; i < 3; i++) u_q[i] <= '0;
				end
				s_q <= '0;
			end
			N_SQ: begin
				s_q <= s_q + 64'(sq);
				r_q <= '0;
				bit_q <= 64'd1 << 62;
			end
			N_SQRT: begin
				if (s_q >= trial_sq) begin
					s_q <= s_q - trial_sq;
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			N_DIVI: begin
				for (int i = 0; i < 3; i++) begin
					rem_q[i] <= RW'(num[i] >> (FW + 1));
					lo_q[i] <= num[i][FW:0];
					q_q[i] <= '0;
				end
			end
			N_DIV: begin
				for (int i = 0; i < 3; i++) begin
					rem_q[i] <= ge[i] ? trial[i] - RW'(len) : trial[i];
					lo_q[i] <= lo_q[i] << 1;
					q_q[i] <= qn[i];
					u_q[i] <= neg_q[i] ? -$signed({1'b0, qn[i]}) : $signed({1'b0, qn[i]});
				end
			end
			default: ;
		endcase
	end

	assign sts = '{done: done_q, zero: zero_q};
	assign ux = u_q[0];
	assign uy = u_q[1];
	assign uz = u_q[2];

endmodule
`default_nettype wire

@@ rtl/core/lavm_fifo.sv @@
`default_nettype none
module lavm_fifo import lavm_pkg::*; #(
	parameter int WIDTH = NUM_FIELDS * DATA_WIDTH_DEF + 2,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic                  not_empty,
	output logic [WIDTH-1:0]      pop_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;

	assign full = cnt_q == CW'(DEPTH);
	assign not_empty = cnt_q != '0;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/lavm_front.sv @@
`default_nettype none
module lavm_front import lavm_pkg::*; #(
	parameter int DW = DATA_WIDTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic signed [DW-1:0] pos_x,
	input  wire logic signed [DW-1:0] pos_y,
	input  wire logic signed [DW-1:0] pos_z,
	input  wire logic signed [DW-1:0] dir_x,
	input  wire logic signed [DW-1:0] dir_y,
	input  wire logic signed [DW-1:0] dir_z,
	input  wire logic signed [DW-1:0] up_x,
	input  wire logic signed [DW-1:0] up_y,
	input  wire logic signed [DW-1:0] up_z,
	input  wire logic                 q_full,
	output logic                      q_push,
	output logic [NUM_FIELDS*DW+1:0]  q_data
);

	logic                        v_s1;
	logic [NUM_FIELDS*DW-1:0]    word_s1;
	logic                        dir_zero_s1, up_zero_s1;

	assign in_stall = v_s1 && q_full;
	assign q_push = v_s1 && !q_full;
	assign q_data = {dir_zero_s1, up_zero_s1, word_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!in_stall) begin
			v_s1 <= in_valid;
		end
	end

	// tag zero-length direction and up vectors so the back end skips their normalize
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			word_s1 <= {pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, up_x, up_y, up_z};
			dir_zero_s1 <= (dir_x == '0) && (dir_y == '0) && (dir_z == '0);
			up_zero_s1 <= (up_x == '0) && (up_y == '0) && (up_z == '0);
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/lavm_back.sv @@
`default_nettype none
module lavm_back import lavm_pkg::*; #(
	parameter int DW = DATA_WIDTH_DEF,
	parameter int FW = FRAC_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    q_valid,
	input  wire logic [NUM_FIELDS*DW+1:0] q_data,
	output logic                         q_pop,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic [1:0]                   row_index,
	output logic signed [DW-1:0]         col0,
	output logic signed [DW-1:0]         col1,
	output logic signed [DW-1:0]         col2,
	output logic signed [DW-1:0]         col3,
	output logic                         last_row,
	output logic                         degenerate
);

	localparam int NW  = (DW > 2 * FW + 3) ? DW : 2 * FW + 3;
	localparam int AW  = FW + 3;
	localparam int BW  = (AW > DW) ? AW : DW;
	localparam int PW  = AW + BW;
	localparam int ACW = PW + 2;
	localparam int XW  = BW + 1;
	localparam int DTW = ACW + 1;
	localparam logic signed [XW-1:0]  SMAX_X = XW'({1'b0, {(DW-1){1'b1}}});
	localparam logic signed [XW-1:0]  SMIN_X = ~SMAX_X;
	localparam logic signed [DTW-1:0] SMAX_D = DTW'({1'b0, {(DW-1){1'b1}}});
	localparam logic signed [DTW-1:0] SMIN_D = ~SMAX_D;
	localparam logic signed [DW-1:0]  ONE_VAL =
		(FW < DW - 1) ? (DW'(1) << FW) : {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [ACW-1:0] HALF = ACW'(1) << (FW - 1);

	back_state_t            st_q;
	logic                   start_q, ok_q, dz_q, uz_q;
	logic [2:0]             k_q;
	logic [1:0]             row_q;
	logic signed [DW-1:0]   pos_q [3];
	logic signed [DW-1:0]   dir_q [3];
	logic signed [DW-1:0]   up_q [3];
	logic signed [AW-1:0]   z_q [3];
	logic signed [AW-1:0]   upn_q [3];
	logic signed [AW-1:0]   x_q [3];
	logic signed [AW-1:0]   y_q [3];
	logic signed [NW-1:0]   t_q [3];
	logic signed [ACW-1:0]  acc_q;

	logic                   out_valid_q, last_q, degen_q;
	logic [1:0]             row_out_q;
	logic signed [DW-1:0]   c0_q, c1_q, c2_q, c3_q;

	norm_sts_t              nsts;
	logic signed [NW-1:0]   nv [3];
	logic signed [FW+1:0]   nu [3];
	logic [1:0]             ai, bi;
	logic signed [AW-1:0]   ma;
	logic signed [BW-1:0]   mb;
	logic signed [PW-1:0]   prod;
	logic signed [ACW-1:0]  diff, ysum;
	logic signed [DTW-1:0]  nd, nd_sh;
	logic signed [DW-1:0]   tcol;
	logic                   emit;

	function automatic logic signed [DW-1:0] sat_ax(input logic signed [AW-1:0] v);
		logic signed [XW-1:0] w;
		w = XW'(v);
		if (w > SMAX_X) return SMAX_X[DW-1:0];
		if (w < SMIN_X) return SMIN_X[DW-1:0];
		return w[DW-1:0];
	endfunction

	lavm_norm #(.FW(FW), .IW(NW)) u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.vx     (nv[0]),
		.vy     (nv[1]),
		.vz     (nv[2]),
		.sts    (nsts),
		.ux     (nu[0]),
		.uy     (nu[1]),
		.uz     (nu[2])
	);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (st_q == ST_NDIR) begin
				nv[i] = NW'(dir_q[i]);
			end else if (st_q == ST_NUP) begin
				nv[i] = NW'(up_q[i]);
			end else begin
				nv[i] = t_q[i];
			end
		end
	end

	// cross product term order: y*z, z*y, z*x, x*z, x*y, y*x
	always_comb begin
		case (k_q)
			3'd0: begin ai = 2'd1; bi = 2'd2; end
			3'd1: begin ai = 2'd2; bi = 2'd1; end
			3'd2: begin ai = 2'd2; bi = 2'd0; end
			3'd3: begin ai = 2'd0; bi = 2'd2; end
			3'd4: begin ai = 2'd0; bi = 2'd1; end
			default: begin ai = 2'd1; bi = 2'd0; end
		endcase
	end

	always_comb begin
		ma = '0;
		mb = '0;
		if (st_q == ST_CROSS1) begin
			ma = upn_q[ai];
			mb = BW'(z_q[bi]);
		end else if (st_q == ST_CROSS2) begin
			ma = z_q[ai];
			mb = BW'(x_q[bi]);
		end else if (row_q == 2'd0) begin
			ma = x_q[k_q[1:0]];
			mb = BW'(pos_q[k_q[1:0]]);
		end else if (row_q == 2'd1) begin
			ma = y_q[k_q[1:0]];
			mb = BW'(pos_q[k_q[1:0]]);
		end else begin
			ma = z_q[k_q[1:0]];
			mb = BW'(pos_q[k_q[1:0]]);
		end
	end

	assign prod = ma * mb;
	assign diff = acc_q - ACW'(prod);
	assign ysum = diff + HALF;
	assign nd = -DTW'(acc_q) + DTW'(HALF);
	assign nd_sh = nd >>> FW;
	assign tcol = (nd_sh > SMAX_D) ? SMAX_D[DW-1:0] :
		(nd_sh < SMIN_D) ? SMIN_D[DW-1:0] : nd_sh[DW-1:0];
	assign emit = (st_q == ST_EMIT) && (!out_valid_q || !out_stall);
	assign q_pop = (st_q == ST_IDLE) && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			start_q <= 1'b0;
			k_q <= '0;
			row_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (q_valid) begin
						start_q <= !q_data[NUM_FIELDS*DW+1];
						st_q <= ST_NDIR;
					end
				end
				ST_NDIR: begin
					if (dz_q || nsts.done) begin
						start_q <= !uz_q;
						st_q <= ST_NUP;
					end
				end
				ST_NUP: begin
					if (uz_q || nsts.done) begin
						k_q <= '0;
						st_q <= ST_CROSS1;
					end
				end
				ST_CROSS1: begin
					k_q <= k_q + 1'b1;
					if (k_q == 3'd5) begin
						start_q <= 1'b1;
						st_q <= ST_NX;
					end
				end
				ST_NX: begin
					if (nsts.done) begin
						k_q <= '0;
						st_q <= ST_CROSS2;
					end
				end
				ST_CROSS2: begin
					k_q <= k_q + 1'b1;
					if (k_q == 3'd5) begin
						k_q <= '0;
						row_q <= '0;
						st_q <= ST_DOT;
					end
				end
				ST_DOT: begin
					k_q <= k_q + 1'b1;
					if (k_q == 3'd2) begin
						st_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit) begin
						row_q <= row_q + 1'b1;
						k_q <= '0;
						if (row_q == 2'd3) begin
							st_q <= ST_IDLE;
						end else if (row_q != 2'd2) begin
							st_q <= ST_DOT;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				for (int i = 0; i < 3; i++) begin
					pos_q[i] <= $signed(q_data[(8 - i) * DW +: DW]);
					dir_q[i] <= $signed(q_data[(5 - i) * DW +: DW]);
					up_q[i] <= $signed(q_data[(2 - i) * DW +: DW]);
				end
				dz_q <= q_data[NUM_FIELDS*DW+1];
				uz_q <= q_data[NUM_FIELDS*DW];
				ok_q <= 1'b1;
			end
			ST_NDIR: begin
				if (dz_q) begin
					for (int i = 0; i < 3; i++) z_q[i] <= '0;
					ok_q <= 1'b0;
				end else if (nsts.done) begin
					for (int i = 0; i < 3; i++) z_q[i] <= -AW'(nu[i]);
					if (nsts.zero) ok_q <= 1'b0;
				end
			end
			ST_NUP: begin
				if (uz_q) begin
					for (int i = 0; i < 3; i++) upn_q[i] <= '0;
					ok_q <= 1'b0;
				end else if (nsts.done) begin
					for (int i = 0; i < 3; i++) upn_q[i] <= AW'(nu[i]);
					if (nsts.zero) ok_q <= 1'b0;
				end
			end
			ST_CROSS1: begin
				if (!k_q[0]) acc_q <= ACW'(prod);
				else t_q[k_q[2:1]] <= diff[NW-1:0];
			end
			ST_NX: begin
				if (nsts.done) begin
					for (int i = 0; i < 3; i++) x_q[i] <= AW'(nu[i]);
					if (nsts.zero) ok_q <= 1'b0;
				end
			end
			ST_CROSS2: begin
				// round half up to the working fraction
				if (!k_q[0]) acc_q <= ACW'(prod);
				else y_q[k_q[2:1]] <= AW'(ysum >>> FW);
			end
			ST_DOT: begin
				acc_q <= (k_q == 3'd0) ? ACW'(prod) : acc_q + ACW'(prod);
			end
			ST_EMIT: begin
				if (emit) begin
					row_out_q <= row_q;
					last_q <= row_q == 2'd3;
					degen_q <= !ok_q;
					case (row_q)
						2'd0: begin
							c0_q <= sat_ax(x_q[0]);
							c1_q <= sat_ax(x_q[1]);
							c2_q <= sat_ax(x_q[2]);
							c3_q <= tcol;
						end
						2'd1: begin
							c0_q <= sat_ax(y_q[0]);
							c1_q <= sat_ax(y_q[1]);
							c2_q <= sat_ax(y_q[2]);
							c3_q <= tcol;
						end
						2'd2: begin
							c0_q <= sat_ax(z_q[0]);
							c1_q <= sat_ax(z_q[1]);
							c2_q <= sat_ax(z_q[2]);
							c3_q <= tcol;
						end
						default: begin
							c0_q <= '0;
							c1_q <= '0;
							c2_q <= '0;
							c3_q <= ONE_VAL;
						end
					endcase
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign row_index = row_out_q;
	assign col0 = c0_q;
	assign col1 = c1_q;
	assign col2 = c2_q;
	assign col3 = c3_q;
	assign last_row = last_q;
	assign degenerate = degen_q;

endmodule
`default_nettype wire

@@ rtl/core/look_at_view_matrix_unit.sv @@
// Flow: the back end works on one item at a time, while the front register and the queue
//   accept new input words meanwhile. The shared normalize unit runs three times per item,
//   and a zero-length direction or up vector skips its run. Four output words per item.
// Reset: arst_n asynchronously clears the queue, the sequencers and the output valid.
`default_nettype none
module look_at_view_matrix_unit import lavm_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic signed [DATA_WIDTH-1:0] pos_x,
	input  wire logic signed [DATA_WIDTH-1:0] pos_y,
	input  wire logic signed [DATA_WIDTH-1:0] pos_z,
	input  wire logic signed [DATA_WIDTH-1:0] dir_x,
	input  wire logic signed [DATA_WIDTH-1:0] dir_y,
	input  wire logic signed [DATA_WIDTH-1:0] dir_z,
	input  wire logic signed [DATA_WIDTH-1:0] up_x,
	input  wire logic signed [DATA_WIDTH-1:0] up_y,
	input  wire logic signed [DATA_WIDTH-1:0] up_z,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [1:0]                        row_index,
	output logic signed [DATA_WIDTH-1:0]      col0,
	output logic signed [DATA_WIDTH-1:0]      col1,
	output logic signed [DATA_WIDTH-1:0]      col2,
	output logic signed [DATA_WIDTH-1:0]      col3,
	output logic                              last_row,
	output logic                              degenerate
);

	localparam int QW = NUM_FIELDS * DATA_WIDTH + 2;

	// front to back queue: the packed input word plus the zero-vector tags
	logic          q_push, q_full, q_pop, q_not_empty;
	logic [QW-1:0] q_wdata, q_rdata;

	// Front: register the input word, tag zero-length vectors, push to the queue.
	lavm_front #(.DW(DATA_WIDTH)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.pos_z    (pos_z),
		.dir_x    (dir_x),
		.dir_y    (dir_y),
		.dir_z    (dir_z),
		.up_x     (up_x),
		.up_y     (up_y),
		.up_z     (up_z),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_wdata)
	);

	// Hold words while the back end works on an earlier one.
	lavm_fifo #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_data  (q_rdata)
	);

	// Back: normalize, cross and dot sequencer; drives the output register.
	lavm_back #(.DW(DATA_WIDTH), .FW(FRAC_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_not_empty),
		.q_data     (q_rdata),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.row_index  (row_index),
		.col0       (col0),
		.col1       (col1),
		.col2       (col2),
		.col3       (col3),
		.last_row   (last_row),
		.degenerate (degenerate)
	);

endmodule
`default_nettype wire
